// ===== rtl/core/mips_special_alu_hilo_macros.svh =====
// Assertion macros for the SPECIAL execute unit
`ifndef MIPS_SPECIAL_ALU_HILO_MACROS_SVH
`define MIPS_SPECIAL_ALU_HILO_MACROS_SVH
`ifndef SYNTHESIS
`define MSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MSA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/msa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msa_pkg;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1A;
   localparam logic [5:0] FN_DIVU    = 6'h1B;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

   localparam logic [31:0] WORD_MASK   = 32'hFFFF_FFFF;
   localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
   localparam logic [31:0] LINK_OFFSET = 32'd8;
   localparam int unsigned QUEUE_DEPTH = 2;

   // operation class decided by the front end
   typedef enum logic [2:0] {
      OP_NONE, OP_ALU, OP_JUMP, OP_SYS, OP_HILO, OP_MUL, OP_DIV
   } op_class_type;

   typedef struct packed {
      logic [5:0]  mode;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
      logic [4:0]  dest_index;
      logic [4:0]  shamt;
      logic [31:0] pc;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [4:0]  write_index;
      logic [31:0] write_value;
      logic        jump_taken;
      logic [31:0] jump_target;
      logic        syscall_raised;
   } rsp_type;

   // decoded instruction handed from front to back
   typedef struct packed {
      op_class_type op_class;
      logic [5:0]   mode;
      logic [31:0]  rs_value;
      logic [31:0]  rt_value;
      logic [4:0]   dest_index;
      logic [31:0]  alu_value;
      logic [31:0]  link_value;
   } uop_type;

endpackage
`default_nettype wire

// ===== rtl/core/msa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msa_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire msa_pkg::req_type req_data,
   output logic                  uop_valid,
   input  wire logic             uop_stall,
   output msa_pkg::uop_type      uop_data
);
   logic             hold_valid_ff;
   msa_pkg::uop_type hold_ff;
   msa_pkg::uop_type dec_in;
   logic [4:0]       amt;
   logic [31:0]      sra_val;

   // decode and compute single-cycle results
   always_comb begin
      dec_in = '0;
      dec_in.mode = req_data.mode;
      dec_in.rs_value = req_data.rs_value;
      dec_in.rt_value = req_data.rt_value;
      dec_in.dest_index = req_data.dest_index;
      dec_in.link_value = req_data.pc + msa_pkg::LINK_OFFSET;
      amt = (req_data.mode[2]) ? req_data.rs_value[4:0] : req_data.shamt;
      sra_val = $unsigned($signed(req_data.rt_value) >>> amt);
      dec_in.op_class = msa_pkg::OP_NONE;
      unique case (req_data.mode)
         msa_pkg::FN_SLL, msa_pkg::FN_SLLV: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = req_data.rt_value << amt;
         end
         msa_pkg::FN_SRL, msa_pkg::FN_SRLV: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = req_data.rt_value >> amt;
         end
         msa_pkg::FN_SRA, msa_pkg::FN_SRAV: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = sra_val;
         end
         msa_pkg::FN_JR, msa_pkg::FN_JALR: dec_in.op_class = msa_pkg::OP_JUMP;
         msa_pkg::FN_SYSCALL: dec_in.op_class = msa_pkg::OP_SYS;
         msa_pkg::FN_MFHI, msa_pkg::FN_MTHI, msa_pkg::FN_MFLO, msa_pkg::FN_MTLO:
            dec_in.op_class = msa_pkg::OP_HILO;
         msa_pkg::FN_MULT, msa_pkg::FN_MULTU: dec_in.op_class = msa_pkg::OP_MUL;
         msa_pkg::FN_DIV, msa_pkg::FN_DIVU: dec_in.op_class = msa_pkg::OP_DIV;
         msa_pkg::FN_ADD, msa_pkg::FN_ADDU: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = req_data.rs_value + req_data.rt_value;
         end
         msa_pkg::FN_SUB, msa_pkg::FN_SUBU: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = req_data.rs_value - req_data.rt_value;
         end
         msa_pkg::FN_AND: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = req_data.rs_value & req_data.rt_value;
         end
         msa_pkg::FN_OR: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = req_data.rs_value | req_data.rt_value;
         end
         msa_pkg::FN_XOR: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = req_data.rs_value ^ req_data.rt_value;
         end
         msa_pkg::FN_NOR: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = ~(req_data.rs_value | req_data.rt_value);
         end
         msa_pkg::FN_SLT: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = {31'd0, ($signed(req_data.rs_value)
                                        < $signed(req_data.rt_value))};
         end
         msa_pkg::FN_SLTU: begin
            dec_in.op_class = msa_pkg::OP_ALU;
            dec_in.alu_value = {31'd0, (req_data.rs_value < req_data.rt_value)};
         end
         default: dec_in.op_class = msa_pkg::OP_NONE;
      endcase
   end

   assign req_stall = hold_valid_ff && uop_stall;
   assign uop_valid = hold_valid_ff;
   assign uop_data  = hold_ff;

   // one decoded entry register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         hold_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         hold_ff <= dec_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/msa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msa_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire msa_pkg::uop_type in_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output msa_pkg::uop_type      out_data
);
   msa_pkg::uop_type entry_ff [msa_pkg::QUEUE_DEPTH];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;
   logic             pop;

   assign in_stall  = (count_ff == 2'(msa_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // two-entry circular queue
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/msa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msa_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             uop_valid,
   output logic                  uop_stall,
   input  wire msa_pkg::uop_type uop_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output msa_pkg::rsp_type      rsp_data,
   output logic                  busy
);
   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIX} state_type;

   state_type        state_ff;
   logic [31:0]      hi_ff, lo_ff;
   logic             out_valid_ff;
   msa_pkg::rsp_type out_ff;
   logic [5:0]       step_ff;
   logic             signed_ff;
   logic             neg_q_ff, neg_r_ff;
   logic [31:0]      quo_ff, rem_ff, dvsr_ff;
   logic [63:0]      prod_ff;
   logic [32:0]      trial;
   logic [31:0]      rem_shift;
   logic             take;
   logic             out_free;
   logic [31:0]      a_mag, b_mag;
   logic [63:0]      prod_in;
   msa_pkg::rsp_type rsp_in;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign take      = uop_valid && (state_ff == ST_IDLE) && out_free;
   assign uop_stall = !take;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign busy      = (state_ff != ST_IDLE);

   // operand magnitudes and product
   always_comb begin
      a_mag = uop_data.rs_value;
      b_mag = uop_data.rt_value;
      if (uop_data.mode == msa_pkg::FN_DIV) begin
         if (uop_data.rs_value[31]) a_mag = 32'd0 - uop_data.rs_value;
         if (uop_data.rt_value[31]) b_mag = 32'd0 - uop_data.rt_value;
      end
      if (uop_data.mode == msa_pkg::FN_MULT) begin
         prod_in = 64'($signed(uop_data.rs_value) * $signed(uop_data.rt_value));
      end else begin
         prod_in = uop_data.rs_value * uop_data.rt_value;
      end
   end

   // one restoring divide step
   always_comb begin
      rem_shift = {rem_ff[30:0], quo_ff[31]};
      trial = {rem_ff, quo_ff[31]} - {1'b0, dvsr_ff};
   end

   // immediate result of single-cycle classes
   always_comb begin
      rsp_in = '0;
      unique case (uop_data.op_class)
         msa_pkg::OP_ALU: begin
            rsp_in.write_enable = 1'b1;
            rsp_in.write_value  = uop_data.alu_value;
         end
         msa_pkg::OP_JUMP: begin
            rsp_in.jump_taken  = 1'b1;
            rsp_in.jump_target = uop_data.rs_value;
            if (uop_data.mode == msa_pkg::FN_JALR) begin
               rsp_in.write_enable = 1'b1;
               rsp_in.write_value  = uop_data.link_value;
            end
         end
         msa_pkg::OP_SYS: rsp_in.syscall_raised = 1'b1;
         msa_pkg::OP_HILO: begin
            if (uop_data.mode == msa_pkg::FN_MFHI) begin
               rsp_in.write_enable = 1'b1;
               rsp_in.write_value  = hi_ff;
            end else if (uop_data.mode == msa_pkg::FN_MFLO) begin
               rsp_in.write_enable = 1'b1;
               rsp_in.write_value  = lo_ff;
            end
         end
         default: rsp_in = '0;
      endcase
      if (uop_data.dest_index == 5'd0) begin
         rsp_in.write_enable = 1'b0;
         rsp_in.write_value  = '0;
      end else if (rsp_in.write_enable) begin
         rsp_in.write_index = uop_data.dest_index;
      end
   end

   // sequencer, HI/LO, and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         hi_ff        <= '0;
         lo_ff        <= '0;
      end else begin
         // response register: load on take, clear once transferred
         if (take)            out_valid_ff <= 1'b1;
         else if (!rsp_stall) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  out_ff       <= rsp_in;
                  if (uop_data.op_class == msa_pkg::OP_HILO) begin
                     if (uop_data.mode == msa_pkg::FN_MTHI) hi_ff <= uop_data.rs_value;
                     if (uop_data.mode == msa_pkg::FN_MTLO) lo_ff <= uop_data.rs_value;
                  end
                  if (uop_data.op_class == msa_pkg::OP_MUL) begin
                     prod_ff  <= prod_in;
                     state_ff <= ST_MUL;
                  end
                  if (uop_data.op_class == msa_pkg::OP_DIV) begin
                     signed_ff <= (uop_data.mode == msa_pkg::FN_DIV);
                     neg_q_ff  <= uop_data.rs_value[31] ^ uop_data.rt_value[31];
                     neg_r_ff  <= uop_data.rs_value[31];
                     quo_ff    <= a_mag;
                     rem_ff    <= '0;
                     dvsr_ff   <= b_mag;
                     step_ff   <= 6'd0;
                     state_ff  <= ST_DIV;
                  end
               end
            end
            ST_MUL: begin
               hi_ff    <= prod_ff[63:32];
               lo_ff    <= prod_ff[31:0];
               state_ff <= ST_IDLE;
            end
            ST_DIV: begin
               if (!trial[32]) begin
                  rem_ff <= trial[31:0];
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= rem_shift;
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd31) state_ff <= ST_FIX;
            end
            ST_FIX: begin
               // zero divisor falls out as all-ones quotient, rem = |rs|
               if (signed_ff && neg_q_ff) lo_ff <= 32'd0 - quo_ff;
               else                       lo_ff <= quo_ff;
               if (signed_ff && neg_r_ff) hi_ff <= 32'd0 - rem_ff;
               else                       hi_ff <= rem_ff;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/mips_special_alu_hilo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// MIPS-I SPECIAL execute unit with HI/LO. Every accepted instruction gives
// exactly one response, in order. A front stage decodes and computes shifts,
// add/sub, logic and set-less-than; a two-entry queue feeds a back end that
// owns HI/LO. Single-cycle instructions sustain one per cycle in the back end
// when not stalled; mult/multu and div/divu keep it busy, the latter for 32
// one-bit restoring steps in a shared divider plus sign fixup. A later
// mfhi/mflo waits for HI/LO to settle. Divide by zero and the signed overflow
// case give the architectural hardware results; add/sub wrap without a trap.
`include "mips_special_alu_hilo_macros.svh"
module mips_special_alu_hilo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire msa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output msa_pkg::rsp_type      rsp_data
);
   logic             f_valid, f_stall;
   msa_pkg::uop_type f_data;
   logic             b_valid, b_stall;
   msa_pkg::uop_type b_data;
   logic             busy;

   msa_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .uop_valid(f_valid), .uop_stall(f_stall), .uop_data(f_data)
   );

   msa_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   msa_back u_back (
      .clock, .reset,
      .uop_valid(b_valid), .uop_stall(b_stall), .uop_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_data, .busy
   );

   `MSA_ASSERT_IMPL(a_no_take_busy, clock, reset, busy, b_stall)
   `MSA_ASSERT_IMPL(a_wr_not_r0, clock, reset, rsp_valid && rsp_data.write_enable,
      rsp_data.write_index != 5'd0)
   `MSA_ASSERT_NEXT(a_take_gives_rsp, clock, reset, b_valid && !b_stall, rsp_valid)
endmodule
`default_nettype wire
